[hdl/lpht_pkg.sv]
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants for the linear-probe hash table: ops, status codes,
// slot tags, hash multipliers and default sizes.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int DEF_CAPACITY    = 1024;
  localparam int DEF_KEY_WIDTH   = 64;
  localparam int DEF_VALUE_WIDTH = 64;

  localparam int LOAD_NUM = 3;
  localparam int LOAD_DEN = 4;

  localparam int OP_W      = 2;
  localparam int KEY_W     = 64;
  localparam int VALUE_W   = 64;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 10;
  localparam int COUNT_W   = 11;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

  typedef logic [1:0] tag_t;
  localparam tag_t TAG_EMPTY = 2'd0;
  localparam tag_t TAG_FULL  = 2'd1;
  localparam tag_t TAG_TOMB  = 2'd2;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

endpackage

[hdl/lpht_if.sv]
// ----------------------------------------------------------------------------
// lpht_if
// Valid/ready channels of the linear-probe hash table: request, result and
// configuration write.
// ----------------------------------------------------------------------------
interface lpht_in_if;
  logic                      valid;
  logic                      ready;
  logic [lpht_pkg::OP_W-1:0]    op;
  logic [lpht_pkg::KEY_W-1:0]   key;
  logic [lpht_pkg::VALUE_W-1:0] value;
  modport source (output valid, op, key, value, input ready);
  modport sink   (input valid, op, key, value, output ready);
endinterface

interface lpht_out_if;
  logic                          valid;
  logic                          ready;
  logic [lpht_pkg::STATUS_W-1:0] status;
  logic [lpht_pkg::VALUE_W-1:0]  value_out;
  logic [lpht_pkg::SLOT_W-1:0]   slot_index;
  logic [lpht_pkg::COUNT_W-1:0]  live_count;
  modport source (output valid, status, value_out, slot_index, live_count, input ready);
  modport sink   (input valid, status, value_out, slot_index, live_count, output ready);
endinterface

interface lpht_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lpht_pkg::COUNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[hdl/lpht_mix.sv]
// ----------------------------------------------------------------------------
// lpht_mix
// Iterative 64-bit mix finalizer and home-slot reduction. One 32x32
// multiplier is shared by all six partial products of the two multiplies
// and, for a capacity that is not a power of two, by the reduction.
// ----------------------------------------------------------------------------
module lpht_mix #(
  parameter int CAPACITY = lpht_pkg::DEF_CAPACITY
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [63:0]                  key,
  output logic                         done,
  output logic [$clog2(CAPACITY)-1:0]  idx
);
  import lpht_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam bit IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
  // Reduction constants: floor(2^32 / CAPACITY) and 2^16 mod CAPACITY.
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / CAPACITY);
  localparam logic [31:0] R16   = 32'(65536 % CAPACITY);
  localparam logic [31:0] CAP32 = 32'(CAPACITY);

  localparam logic [3:0] P_IDLE = 4'd0;
  localparam logic [3:0] P_XS30 = 4'd1;
  localparam logic [3:0] P_MUL1 = 4'd2;
  localparam logic [3:0] P_XS27 = 4'd3;
  localparam logic [3:0] P_MUL2 = 4'd4;
  localparam logic [3:0] P_XS31 = 4'd5;
  localparam logic [3:0] P_FOLD = 4'd6;
  localparam logic [3:0] P_QUOT = 4'd7;
  localparam logic [3:0] P_REM  = 4'd8;

  logic [3:0]    phase_r, phase_nxt;
  logic [1:0]    sub_r, sub_nxt;
  logic [63:0]   x_r, x_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic [31:0]   red_r, red_nxt;
  logic [31:0]   quo_r, quo_nxt;
  logic [IW-1:0] rem_r, rem_nxt;
  logic          done_r, done_nxt;
  logic [IW-1:0] idx_r, idx_nxt;

  logic [63:0]   mul_c;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;
  logic [31:0]   red_diff;

  assign mul_c = (phase_r == P_MUL1) ? MIX_C1 : MIX_C2;

  always_comb begin
    case (phase_r)
      P_FOLD: begin
        mul_a = 32'(rem_r);
        mul_b = R16;
      end
      P_QUOT: begin
        mul_a = red_r;
        mul_b = RECIP;
      end
      P_REM: begin
        mul_a = quo_r;
        mul_b = CAP32;
      end
      default: begin
        case (sub_r)
          2'd0: begin
            mul_a = x_r[31:0];
            mul_b = mul_c[31:0];
          end
          2'd1: begin
            mul_a = x_r[31:0];
            mul_b = mul_c[63:32];
          end
          default: begin
            mul_a = x_r[63:32];
            mul_b = mul_c[31:0];
          end
        endcase
      end
    endcase
  end

  assign prod     = {32'b0, mul_a} * {32'b0, mul_b};
  assign red_diff = red_r - prod[31:0];

  always_comb begin
    phase_nxt = phase_r;
    sub_nxt   = sub_r;
    x_nxt     = x_r;
    acc_nxt   = acc_r;
    red_nxt   = red_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    done_nxt  = 1'b0;
    idx_nxt   = idx_r;
    case (phase_r)
      P_IDLE: begin
        if (start) begin
          x_nxt     = key;
          phase_nxt = P_XS30;
        end
      end
      P_XS30: begin
        x_nxt     = x_r ^ (x_r >> 30);
        sub_nxt   = 2'd0;
        phase_nxt = P_MUL1;
      end
      P_XS27: begin
        x_nxt     = x_r ^ (x_r >> 27);
        sub_nxt   = 2'd0;
        phase_nxt = P_MUL2;
      end
      P_MUL1, P_MUL2: begin
        // Low 64 bits of the product: lo*lo plus both cross terms shifted up.
        if (sub_r == 2'd0) begin
          acc_nxt = prod;
          sub_nxt = 2'd1;
        end else if (sub_r == 2'd1) begin
          acc_nxt = acc_r + {prod[31:0], 32'b0};
          sub_nxt = 2'd2;
        end else begin
          x_nxt     = acc_r + {prod[31:0], 32'b0};
          phase_nxt = (phase_r == P_MUL1) ? P_XS27 : P_XS31;
        end
      end
      P_XS31: begin
        x_nxt = x_r ^ (x_r >> 31);
        if (IS_POW2) begin
          done_nxt  = 1'b1;
          idx_nxt   = x_nxt[IW-1:0];
          phase_nxt = P_IDLE;
        end else begin
          rem_nxt   = '0;
          sub_nxt   = 2'd0;
          phase_nxt = P_FOLD;
        end
      end
      P_FOLD: begin
        // Horner step over 16-bit chunks from the top, with 2^16 replaced by
        // its residue. The sum stays below 2^32.
        red_nxt   = prod[31:0] + {16'b0, x_r[63:48]};
        x_nxt     = x_r << 16;
        phase_nxt = P_QUOT;
      end
      P_QUOT: begin
        quo_nxt   = prod[63:32];
        phase_nxt = P_REM;
      end
      P_REM: begin
        // The reciprocal quotient is at most one short, so one subtract fixes it.
        rem_nxt = (red_diff >= CAP32) ? IW'(red_diff - CAP32) : IW'(red_diff);
        if (sub_r == 2'd3) begin
          done_nxt  = 1'b1;
          idx_nxt   = rem_nxt;
          phase_nxt = P_IDLE;
        end else begin
          sub_nxt   = sub_r + 2'd1;
          phase_nxt = P_FOLD;
        end
      end
      default: phase_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    sub_r <= sub_nxt;
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
    red_r <= red_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    idx_r <= idx_nxt;
  end

  assign done = done_r;
  assign idx  = idx_r;

endmodule

[hdl/linear_probe_hash_table.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Fixed-capacity key/value table with open addressing, linear probing and
// tombstones, driven by a small sequencer around the hash unit and the
// slot memories.
// ----------------------------------------------------------------------------
//   channel   direction   carries
//   in_ch     sink        op, key, value
//   out_ch    source      status, value_out, slot_index, live_count
//   cfg_ch    sink        max_entries (always ready)
//
// An item is taken in the idle step, hashed on the shared 32x32 multiplier
// (with a modular reduction added when CAPACITY is not a power of two), then
// probed slot by slot and then retired. Clear sweeps the tag memory one slot
// per cycle, and the same sweep runs after reset before the first item is
// taken. A stalled result holds the sequencer in its retire step.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int CAPACITY    = lpht_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH   = lpht_pkg::DEF_KEY_WIDTH,
  parameter int VALUE_WIDTH = lpht_pkg::DEF_VALUE_WIDTH
) (
  input  logic         clk,
  input  logic         rst_n,
  lpht_in_if.sink      in_ch,
  lpht_out_if.source   out_ch,
  lpht_cfg_if.sink     cfg_ch
);
  import lpht_pkg::*;

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int LIM  = (CAPACITY * LOAD_NUM) / LOAD_DEN;
  localparam logic [COUNT_W-1:0] MAX_RST = (LIM > 2047) ? 11'd2047 : COUNT_W'(LIM);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  tag_t                   tag_mem [CAPACITY];
  logic [KEY_WIDTH-1:0]   key_mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];

  logic [2:0]             state_r, state_nxt;
  logic [OP_W-1:0]        op_r, op_nxt;
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic [IW-1:0]          n_r, n_nxt;
  logic [IW-1:0]          ft_r, ft_nxt;
  logic                   ftv_r, ftv_nxt;
  logic [IW-1:0]          tgt_r, tgt_nxt;
  logic                   tgtok_r, tgtok_nxt;
  logic                   tgttomb_r, tgttomb_nxt;
  logic                   hit_r, hit_nxt;
  logic [VALUE_WIDTH-1:0] hitval_r, hitval_nxt;
  logic [IW-1:0]          clr_r, clr_nxt;
  logic                   clrrep_r, clrrep_nxt;
  logic [CW-1:0]          entry_r, entry_nxt;
  logic [CW-1:0]          tomb_r, tomb_nxt;
  logic [COUNT_W-1:0]     max_r;

  logic                   ovalid_r, ovalid_nxt;
  logic [STATUS_W-1:0]    ostat_r, ostat_nxt;
  logic [VALUE_W-1:0]     oval_r, oval_nxt;
  logic [SLOT_W-1:0]      oslot_r, oslot_nxt;
  logic [COUNT_W-1:0]     olive_r, olive_nxt;

  logic [IW-1:0]          rd_addr;
  tag_t                   tag_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;

  logic                   tag_we, kv_we;
  logic [IW-1:0]          wr_addr;
  tag_t                   tag_wd;

  logic                   mix_start, mix_done;
  logic [IW-1:0]          mix_idx;
  logic                   accept, out_free;
  logic [IW-1:0]          idx_inc;
  logic [IW-1:0]          ft_now;
  logic                   ftv_now;

  lpht_mix #(.CAPACITY(CAPACITY)) u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mix_start),
    .key   (64'(key_r)),
    .done  (mix_done),
    .idx   (mix_idx)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !ovalid_r || out_ch.ready;
  assign idx_inc      = (idx_r == IW'(CAPACITY - 1)) ? '0 : idx_r + 1'b1;
  assign ftv_now      = ftv_r || (tag_q == TAG_TOMB);
  assign ft_now       = ftv_r ? ft_r : idx_r;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    idx_nxt     = idx_r;
    n_nxt       = n_r;
    ft_nxt      = ft_r;
    ftv_nxt     = ftv_r;
    tgt_nxt     = tgt_r;
    tgtok_nxt   = tgtok_r;
    tgttomb_nxt = tgttomb_r;
    hit_nxt     = hit_r;
    hitval_nxt  = hitval_r;
    clr_nxt     = clr_r;
    clrrep_nxt  = clrrep_r;
    entry_nxt   = entry_r;
    tomb_nxt    = tomb_r;
    ovalid_nxt  = ovalid_r && !out_ch.ready;
    ostat_nxt   = ostat_r;
    oval_nxt    = oval_r;
    oslot_nxt   = oslot_r;
    olive_nxt   = olive_r;
    mix_start   = 1'b0;
    rd_addr     = idx_r;
    tag_we      = 1'b0;
    kv_we       = 1'b0;
    wr_addr     = tgt_r;
    tag_wd      = TAG_EMPTY;

    case (state_r)
      S_CLR: begin
        tag_we  = 1'b1;
        wr_addr = clr_r;
        tag_wd  = TAG_EMPTY;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IW'(CAPACITY - 1)) begin
          state_nxt = clrrep_r ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt  = in_ch.op;
          key_nxt = in_ch.key[KEY_WIDTH-1:0];
          val_nxt = in_ch.value[VALUE_WIDTH-1:0];
          if (in_ch.op == OP_CLEAR) begin
            clr_nxt    = '0;
            clrrep_nxt = 1'b1;
            entry_nxt  = '0;
            tomb_nxt   = '0;
            state_nxt  = S_CLR;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        mix_start = !mix_done;
        rd_addr   = mix_idx;
        if (mix_done) begin
          idx_nxt   = mix_idx;
          n_nxt     = '0;
          ftv_nxt   = 1'b0;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        // tag_q, key_q and val_q belong to slot idx_r; the next slot is
        // addressed in the same cycle so its read is ready when idx_r moves on.
        rd_addr = idx_inc;
        if (tag_q == TAG_EMPTY) begin
          tgt_nxt     = ft_now;
          tgtok_nxt   = 1'b1;
          tgttomb_nxt = ftv_r;
          hit_nxt     = 1'b0;
          state_nxt   = S_FIN;
        end else if (tag_q == TAG_FULL && key_q == key_r) begin
          tgt_nxt    = idx_r;
          tgtok_nxt  = 1'b1;
          hit_nxt    = 1'b1;
          hitval_nxt = val_q;
          state_nxt  = S_FIN;
        end else if (n_r == IW'(CAPACITY - 1)) begin
          tgt_nxt     = ft_now;
          tgtok_nxt   = ftv_now;
          tgttomb_nxt = 1'b1;
          hit_nxt     = 1'b0;
          state_nxt   = S_FIN;
        end else begin
          if (tag_q == TAG_TOMB && !ftv_r) begin
            ft_nxt  = idx_r;
            ftv_nxt = 1'b1;
          end
          idx_nxt = idx_inc;
          n_nxt   = n_r + 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          oval_nxt   = '0;
          oslot_nxt  = '0;
          state_nxt  = S_IDLE;
          clrrep_nxt = 1'b0;
          if (op_r == OP_CLEAR) begin
            ostat_nxt = ST_CLEARED;
          end else if (op_r == OP_INSERT) begin
            if (hit_r) begin
              kv_we     = 1'b1;
              oslot_nxt = SLOT_W'(tgt_r);
              ostat_nxt = ST_UPDATED;
            end else if (CMPW'(entry_r) >= CMPW'(max_r) || !tgtok_r) begin
              ostat_nxt = ST_FULL;
            end else begin
              kv_we     = 1'b1;
              tag_we    = 1'b1;
              tag_wd    = TAG_FULL;
              if (tgttomb_r && tomb_r != '0) begin
                tomb_nxt = tomb_r - 1'b1;
              end
              entry_nxt = entry_r + 1'b1;
              oslot_nxt = SLOT_W'(tgt_r);
              ostat_nxt = ST_NEW;
            end
          end else if (hit_r) begin
            oval_nxt  = VALUE_W'(hitval_r);
            oslot_nxt = SLOT_W'(tgt_r);
            ostat_nxt = ST_FOUND;
            if (op_r == OP_REMOVE) begin
              tag_we   = 1'b1;
              tag_wd   = TAG_TOMB;
              tomb_nxt = tomb_r + 1'b1;
              if (entry_r != '0) begin
                entry_nxt = entry_r - 1'b1;
              end
            end
          end else begin
            ostat_nxt = ST_MISS;
          end
          olive_nxt = COUNT_W'(entry_nxt);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      clrrep_r <= 1'b0;
      entry_r  <= '0;
      tomb_r   <= '0;
      ovalid_r <= 1'b0;
      max_r    <= MAX_RST;
      n_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      clrrep_r <= clrrep_nxt;
      entry_r  <= entry_nxt;
      tomb_r   <= tomb_nxt;
      ovalid_r <= ovalid_nxt;
      n_r      <= n_nxt;
      if (cfg_ch.valid) begin
        max_r <= cfg_ch.data;
      end
    end
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    idx_r     <= idx_nxt;
    ft_r      <= ft_nxt;
    ftv_r     <= ftv_nxt;
    tgt_r     <= tgt_nxt;
    tgtok_r   <= tgtok_nxt;
    tgttomb_r <= tgttomb_nxt;
    hit_r     <= hit_nxt;
    hitval_r  <= hitval_nxt;
    ostat_r   <= ostat_nxt;
    oval_r    <= oval_nxt;
    oslot_r   <= oslot_nxt;
    olive_r   <= olive_nxt;
  end

  // Slot memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[wr_addr] <= tag_wd;
    end
    tag_q <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (kv_we) begin
      key_mem[wr_addr] <= key_r;
    end
    key_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (kv_we) begin
      val_mem[wr_addr] <= val_r;
    end
    val_q <= val_mem[rd_addr];
  end

  assign out_ch.valid      = ovalid_r;
  assign out_ch.status     = ostat_r;
  assign out_ch.value_out  = oval_r;
  assign out_ch.slot_index = oslot_r;
  assign out_ch.live_count = olive_r;

endmodule

[verif/lpht_scoreboard.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpht_scoreboard
// Shadow table of the linear-probe hash table. It predicts each result from
// the accepted items and compares the results that come back in order.
// ----------------------------------------------------------------------------
class lpht_scoreboard;
  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] value_out;
    logic [9:0]  slot_index;
    logic [10:0] live_count;
  } table_result_t;

  localparam int CAP = 1024;

  lpht_pkg::tag_t tags[CAP];
  logic [63:0]    keys[CAP];
  logic [63:0]    vals[CAP];
  int unsigned    live_total;
  int unsigned    tomb_total;
  int unsigned    entry_limit;
  table_result_t  pending[$];
  int             error_count;

  function new();
    wipe();
    entry_limit = 768;
    error_count = 0;
  endfunction

  function void wipe();
    foreach (tags[i]) tags[i] = lpht_pkg::TAG_EMPTY;
    live_total = 0;
    tomb_total = 0;
  endfunction

  function logic [63:0] mix(logic [63:0] x);
    x = x ^ (x >> 30);
    x = x * lpht_pkg::MIX_C1;
    x = x ^ (x >> 27);
    x = x * lpht_pkg::MIX_C2;
    x = x ^ (x >> 31);
    return x;
  endfunction

  // Returns the matching slot, else the slot a new key would take, else -1.
  function int find_slot(logic [63:0] key, output bit hit);
    int idx;
    int tomb_slot;
    idx = int'(mix(key) % CAP);
    tomb_slot = -1;
    hit = 0;
    for (int n = 0; n < CAP; n++) begin
      if (tags[idx] == lpht_pkg::TAG_EMPTY) begin
        return (tomb_slot >= 0) ? tomb_slot : idx;
      end
      if (tags[idx] == lpht_pkg::TAG_TOMB) begin
        if (tomb_slot < 0) tomb_slot = idx;
      end else if (keys[idx] == key) begin
        hit = 1;
        return idx;
      end
      idx = (idx + 1) % CAP;
    end
    return tomb_slot;
  endfunction

  function void note_request(logic [1:0] op, logic [63:0] key, logic [63:0] value);
    table_result_t r;
    bit hit;
    int s;
    r = '0;
    r.status = lpht_pkg::ST_MISS;
    if (op == lpht_pkg::OP_CLEAR) begin
      wipe();
      r.status = lpht_pkg::ST_CLEARED;
    end else begin
      s = find_slot(key, hit);
      if (op == lpht_pkg::OP_INSERT) begin
        if (hit) begin
          vals[s] = value;
          r.slot_index = s[9:0];
          r.status = lpht_pkg::ST_UPDATED;
        end else if (live_total >= entry_limit || s < 0) begin
          r.status = lpht_pkg::ST_FULL;
        end else begin
          if (tags[s] == lpht_pkg::TAG_TOMB && tomb_total > 0) tomb_total--;
          tags[s] = lpht_pkg::TAG_FULL;
          keys[s] = key;
          vals[s] = value;
          live_total++;
          r.slot_index = s[9:0];
          r.status = lpht_pkg::ST_NEW;
        end
      end else if (hit) begin
        r.value_out = vals[s];
        r.slot_index = s[9:0];
        r.status = lpht_pkg::ST_FOUND;
        if (op == lpht_pkg::OP_REMOVE) begin
          tags[s] = lpht_pkg::TAG_TOMB;
          if (live_total > 0) live_total--;
          tomb_total++;
        end
      end
    end
    r.live_count = live_total[10:0];
    pending.push_back(r);
  endfunction

  function void check_result(table_result_t got);
    table_result_t exp;
    if (pending.size() == 0) begin
      $error("unexpected result item status=%0d", got.status);
      error_count++;
      return;
    end
    exp = pending.pop_front();
    if (got.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, got.status);
      error_count++;
    end
    if (got.value_out !== exp.value_out) begin
      $error("value_out: expected %h, got %h", exp.value_out, got.value_out);
      error_count++;
    end
    if (got.slot_index !== exp.slot_index) begin
      $error("slot_index: expected %0d, got %0d", exp.slot_index, got.slot_index);
      error_count++;
    end
    if (got.live_count !== exp.live_count) begin
      $error("live_count: expected %0d, got %0d", exp.live_count, got.live_count);
      error_count++;
    end
  endfunction
endclass

[verif/linear_probe_hash_table_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_test
// Drives inserts, lookups, removes and clears through the hash table under
// several entry limits and idle patterns, and checks every result against a
// shadow table.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_test;
  import lpht_pkg::*;

  logic clk = 0;
  logic rst_n = 0;

  lpht_in_if  in_ch();
  lpht_out_if out_ch();
  lpht_cfg_if cfg_ch();

  linear_probe_hash_table u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  lpht_scoreboard table_model = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic [63:0] key_pool[16];

  initial begin
    in_ch.valid = 0;
    in_ch.op = OP_INSERT;
    in_ch.key = '0;
    in_ch.value = '0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.data = '0;
  end

  // Result side: ready is drawn each falling edge, results sampled at rising.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      table_model.check_result({out_ch.status, out_ch.value_out,
                                out_ch.slot_index, out_ch.live_count});
    end
  end

  // Valid stays high between back-to-back items and drops only while idle.
  task automatic send_request(logic [1:0] op, logic [63:0] key, logic [63:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.op <= op;
    in_ch.key <= key;
    in_ch.value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    table_model.note_request(op, key, value);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (table_model.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_limit(logic [10:0] limit);
    drain();
    cfg_ch.valid <= 1;
    cfg_ch.data <= limit;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    table_model.entry_limit = limit;
    @(negedge clk);
    cfg_ch.valid <= 0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly keys from a small pool so that hits, updates and removes happen.
  task automatic random_phase(int count, int pool_size);
    logic [1:0] op;
    logic [63:0] key;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) op = OP_INSERT;
      else if (pick < 75) op = OP_LOOKUP;
      else if (pick < 99) op = OP_REMOVE;
      else op = OP_CLEAR;
      key = ($urandom_range(9) < 8) ? key_pool[$urandom_range(pool_size - 1)] : rand64();
      send_request(op, key, rand64());
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1;
    foreach (key_pool[i]) key_pool[i] = rand64();
    key_pool[0] = '0;
    key_pool[1] = '1;

    // Directed: extremes, every op, update at limit, new key at limit.
    send_request(OP_LOOKUP, 64'd0, 64'd0);
    send_request(OP_INSERT, 64'd0, '1);
    send_request(OP_INSERT, '1, 64'd0);
    send_request(OP_INSERT, 64'd0, 64'h5555_AAAA_5555_AAAA);
    send_request(OP_LOOKUP, 64'd0, 64'd0);
    send_request(OP_LOOKUP, '1, 64'd0);
    send_request(OP_REMOVE, '1, 64'd0);
    send_request(OP_REMOVE, '1, 64'd0);
    send_request(OP_INSERT, '1, 64'h1234);
    write_limit(11'd1);
    send_request(OP_INSERT, 64'hAAAA_5555_AAAA_5555, 64'd7);
    send_request(OP_INSERT, 64'd0, 64'd9);
    send_request(OP_CLEAR, 64'd0, 64'd0);
    send_request(OP_INSERT, 64'h8000_0000_0000_0001, '1);
    send_request(OP_INSERT, 64'h42, 64'd3);
    send_request(OP_REMOVE, 64'h8000_0000_0000_0001, 64'd0);
    send_request(OP_INSERT, 64'h42, 64'd3);
    write_limit(11'd0);
    send_request(OP_INSERT, 64'h99, 64'd1);
    send_request(OP_INSERT, 64'h42, 64'd4);
    write_limit(11'd2047);
    send_request(OP_CLEAR, 64'd0, 64'd0);

    // Idle patterns: none, sender, receiver, both.
    random_phase(400, 16);
    drain();
    send_idle_pct = 74;
    write_limit(11'd8);
    random_phase(300, 16);
    send_idle_pct = 0;
    recv_stall_pct = 74;
    write_limit(11'd1024);
    random_phase(300, 16);
    send_idle_pct = 35;
    recv_stall_pct = 35;
    write_limit(11'd3);
    random_phase(250, 8);
    // Fill a large table with fresh keys, then churn with removes.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_limit(11'd1024);
    for (int i = 0; i < 300; i++) send_request(OP_INSERT, rand64(), rand64());
    random_phase(100, 16);

    drain();
    if (table_model.error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
